>>> src/pgb_pkg.sv
// ----------------------------------------------------------------------------
// pgb_pkg: shared types and constants for the particle grid binning block
// Cell word layout, operation codes, register indexes and the Q12.8 coordinate
// truncation used when a particle is binned.
// ----------------------------------------------------------------------------
package pgb_pkg;

	// default grid bounds
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// compare width: holds any bound up to 4096
	localparam int CMP_W = 13;

	// register port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;
	localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 9'd256;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BIN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		ST_SWEEP = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	// one grid cell as held in memory
	typedef struct packed {
		logic [7:0]  material;
		logic [15:0] count;
	} cell_t;

	// truncated coordinate: ok is low when the value is -1.0 or below
	typedef struct packed {
		logic        ok;
		logic [10:0] ipart;
	} coord_t;

	// Q12.8 to integer, toward zero
	function automatic coord_t trunc_coord(input logic [19:0] raw);
		coord_t res;
		res.ok    = 1'b1;
		res.ipart = raw[18:8];
		if (raw[19]) begin
			// above -1.0 truncates to zero, anything lower is rejected
			res.ok    = (raw[19:8] == 12'hFFF) && (raw[7:0] != 8'd0);
			res.ipart = 11'd0;
		end
		return res;
	endfunction

endpackage

>>> src/pgb_cell_mem.sv
// ----------------------------------------------------------------------------
// pgb_cell_mem: cell store
// Single-port-write, single-port-read synchronous memory, registered read data
// (read-before-write when both ports hit the same entry in one cycle).
// ----------------------------------------------------------------------------
module pgb_cell_mem import pgb_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cell_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output cell_t         rd_data
);

	cell_t mem [DEPTH];
	cell_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/particle_grid_binning.sv
// ----------------------------------------------------------------------------
// particle_grid_binning: occupancy grid built from a particle stream
// Pipeline: stage 1, then the output register. Throughput: one bin or read
// per cycle unless the output stalls; the read-modify-write path forwards.
// Clear: a sweep of MAX_WIDTH*MAX_HEIGHT cells (65536 by default), one cell
// per cycle through the memory write port; no input is taken meanwhile.
// Reset: registers to 256 x 256, then the same sweep before the first beat.
// ----------------------------------------------------------------------------
module particle_grid_binning import pgb_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// register port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            operation,
	input  logic signed [19:0]    pos_x,
	input  logic signed [19:0]    pos_y,
	input  logic [7:0]            particle_material,
	input  logic [7:0]            read_col,
	input  logic [7:0]            read_row,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic [7:0]            cell_material,
	output logic [15:0]           cell_density
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	// configuration
	logic [CFG_DATA_W-1:0] grid_width_q;
	logic [CFG_DATA_W-1:0] grid_height_q;

	// control
	state_t        state_q;
	state_t        state_nxt;
	logic          sweep_on;
	logic [AW-1:0] clr_idx_q;

	// incoming beat decode
	op_t              op_in;
	coord_t           cx;
	coord_t           cy;
	logic             coord_ok;
	logic [CMP_W-1:0] col_in;
	logic [CMP_W-1:0] row_in;
	logic [CMP_W-1:0] eff_w;
	logic [CMP_W-1:0] eff_h;
	logic             hit_in;
	logic [AW-1:0]    addr_in;
	logic             in_acc;

	// stage 1: memory data arrives
	logic          valid_s1;
	op_t           op_s1;
	logic          hit_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mat_s1;
	logic          fwd_s1;
	cell_t         fwd_data_s1;

	logic  adv;
	cell_t rd_cell;
	cell_t cur_cell;
	cell_t new_cell;
	logic  bin_wr;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	cell_t         mem_wdata;

	// output register
	logic        out_valid_q;
	logic        accepted_q;
	logic [7:0]  cell_material_q;
	logic [15:0] cell_density_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_DIM_RESET;
			grid_height_q <= GRID_DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bounds in use, clipped to the array size
	always_comb begin
		eff_w = CMP_W'(grid_width_q);
		eff_h = CMP_W'(grid_height_q);
		if (eff_w > CMP_W'(MAX_WIDTH)) begin
			eff_w = CMP_W'(MAX_WIDTH);
		end
		if (eff_h > CMP_W'(MAX_HEIGHT)) begin
			eff_h = CMP_W'(MAX_HEIGHT);
		end
	end

	// decode of the incoming beat
	assign op_in = op_t'(operation);
	assign cx    = trunc_coord(pos_x);
	assign cy    = trunc_coord(pos_y);

	always_comb begin
		coord_ok = 1'b0;
		col_in   = CMP_W'(read_col);
		row_in   = CMP_W'(read_row);
		unique case (op_in)
			OP_BIN: begin
				coord_ok = cx.ok && cy.ok;
				col_in   = CMP_W'(cx.ipart);
				row_in   = CMP_W'(cy.ipart);
			end
			OP_READ: begin
				coord_ok = 1'b1;
			end
			default: ;
		endcase
	end

	assign hit_in  = coord_ok && (col_in < eff_w) && (row_in < eff_h);
	// cells stay put whatever the configured width
	assign addr_in = AW'(AW'(row_in) * AW'(MAX_WIDTH)) + AW'(col_in);

	// handshake
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = sweep_on || (valid_s1 && ((op_s1 == OP_CLEAR) || !adv));
	assign in_acc   = in_valid && !in_stall;

	// state machine: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (clr_idx_q == LAST_CELL) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (adv && (op_s1 == OP_CLEAR)) begin
					state_nxt = ST_SWEEP;
				end
			end
			default: state_nxt = ST_SWEEP;
		endcase
	end

	// state machine: outputs
	always_comb begin
		unique case (state_q)
			ST_SWEEP: sweep_on = 1'b1;
			ST_RUN:   sweep_on = 1'b0;
			default:  sweep_on = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (sweep_on) begin
				clr_idx_q <= (clr_idx_q == LAST_CELL) ? '0 : clr_idx_q + AW'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			// same cell written this edge: memory returns the stale word
			fwd_s1   <= bin_wr && (addr_s1 == addr_in);
		end else if (adv) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1       <= op_in;
			hit_s1      <= hit_in;
			addr_s1     <= addr_in;
			mat_s1      <= particle_material;
			fwd_data_s1 <= new_cell;
		end
	end

	// modify
	assign cur_cell          = fwd_s1 ? fwd_data_s1 : rd_cell;
	assign new_cell.material = mat_s1;
	assign new_cell.count    = (cur_cell.count == COUNT_MAX) ? COUNT_MAX
		: cur_cell.count + 16'd1;
	assign bin_wr            = adv && (op_s1 == OP_BIN) && hit_s1;

	// write port: sweep or bin write-back
	assign mem_we    = sweep_on || bin_wr;
	assign mem_waddr = sweep_on ? clr_idx_q : addr_s1;
	assign mem_wdata = sweep_on ? cell_t'('0) : new_cell;

	pgb_cell_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_cell_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (in_acc),
		.rd_addr (addr_in),
		.rd_data (rd_cell)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted_q      <= ((op_s1 == OP_BIN) || (op_s1 == OP_READ)) && hit_s1;
			cell_material_q <= 8'd0;
			cell_density_q  <= 16'd0;
			if ((op_s1 == OP_READ) && hit_s1) begin
				cell_material_q <= cur_cell.material;
				cell_density_q  <= cur_cell.count;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign cell_material = cell_material_q;
	assign cell_density  = cell_density_q;

	// checks
	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_on |-> in_stall)
		else $error("input taken during clear sweep");

	a_no_bin_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_on && bin_wr))
		else $error("bin write-back collides with clear sweep");

	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (op_s1 == OP_CLEAR)) |=> sweep_on)
		else $error("clear retired without a sweep");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarding flag set with stage 1 empty");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the particle grid binning block
// Drives bin, read, clear and no-op beats through the valid/stall channels,
// keeps its own copy of the grid and the two size registers, and checks every
// result beat field by field against that copy or a hand-written result.
// A directed table comes first, then a back-to-back burst on one cell, then
// random traffic over several grid sizes, zero and oversized ones among them.
// ----------------------------------------------------------------------------
module tb_top;
	import pgb_pkg::*;

	localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	// one beat on the input channel, with an optional hand-written result
	typedef struct packed {
		op_t         op;
		logic [19:0] px;
		logic [19:0] py;
		logic [7:0]  mat;
		logic [7:0]  col;
		logic [7:0]  row;
		logic        fixed;
		logic        want_acc;
		logic [7:0]  want_mat;
		logic [15:0] want_cnt;
	} grid_beat_t;

	// one result beat
	typedef struct packed {
		logic        acc;
		logic [7:0]  material;
		logic [15:0] density;
	} cell_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            operation;
	logic signed [19:0]    pos_x;
	logic signed [19:0]    pos_y;
	logic [7:0]            particle_material;
	logic [7:0]            read_col;
	logic [7:0]            read_row;
	logic                  out_valid;
	logic                  out_stall;
	logic                  accepted;
	logic [7:0]            cell_material;
	logic [15:0]           cell_density;

	// bench copy of the grid and the size registers
	cell_t          grid_cells [CELLS];
	logic [8:0]     grid_w_reg;
	logic [8:0]     grid_h_reg;
	cell_reply_t    pending_replies [$];
	int             mismatches;
	int             clears_left;
	bit             no_gaps;

	particle_grid_binning u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.particle_material (particle_material),
		.read_col          (read_col),
		.read_row          (read_row),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.accepted          (accepted),
		.cell_material     (cell_material),
		.cell_density      (cell_density)
	);

	// directed table: extremes, every operation, rounding toward zero
	grid_beat_t directed_rows [21] = '{
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd255, 8'd255, 1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_BIN,   20'h00000, 20'h00000, 8'hA5, 8'd0,   8'd0,   1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 8'hA5, 16'd1},
		'{OP_BIN,   20'h0FFFF, 20'h0FFFF, 8'hFF, 8'd0,   8'd0,   1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_BIN,   20'h10000, 20'h00000, 8'h11, 8'd0,   8'd0,   1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_BIN,   20'h7FFFF, 20'h7FFFF, 8'h22, 8'd0,   8'd0,   1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_BIN,   20'h80000, 20'h80000, 8'h33, 8'd0,   8'd0,   1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_BIN,   20'hFFFFF, 20'hFFF80, 8'h03, 8'd0,   8'd0,   1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_BIN,   20'hFFF00, 20'h00000, 8'h44, 8'd0,   8'd0,   1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_BIN,   20'h00000, 20'hFFF00, 8'h55, 8'd0,   8'd0,   1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 8'h03, 16'd2},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd255, 8'd255, 1'b1, 1'b1, 8'hFF, 16'd1},
		'{OP_NONE,  20'h00000, 20'h00000, 8'h77, 8'd0,   8'd0,   1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 8'h03, 16'd2},
		'{OP_CLEAR, 20'hFFFFF, 20'hFFFFF, 8'hFF, 8'd255, 8'd255, 1'b1, 1'b0, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd255, 8'd255, 1'b1, 1'b1, 8'h00, 16'd0},
		'{OP_BIN,   20'h01180, 20'h00340, 8'h42, 8'd0,   8'd0,   1'b0, 1'b0, 8'h00, 16'd0},
		'{OP_BIN,   20'h011FF, 20'h00301, 8'h43, 8'd0,   8'd0,   1'b0, 1'b0, 8'h00, 16'd0},
		'{OP_READ,  20'h00000, 20'h00000, 8'h00, 8'd17,  8'd3,   1'b1, 1'b1, 8'h43, 16'd2}
	};

	// register settings per random phase; the last two are drawn at run time
	int phase_w [8] = '{256, 1, 0,  511, 12, 256, 0, 0};
	int phase_h [8] = '{256, 1, 37, 300, 9,  0,   0, 0};

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// size register above the maximum acts as the maximum
	function automatic int eff_dim(input logic [8:0] r);
		return (r > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(r);
	endfunction

	// Q12.8 toward zero; fails at -1.0 and below
	function automatic bit coord_to_cell(input logic [19:0] raw, output int idx);
		int v;
		v = int'($signed(raw));
		idx = 0;
		if (v <= -256)
			return 1'b0;
		idx = (v < 0) ? 0 : (v >>> 8);
		return 1'b1;
	endfunction

	// apply one beat to the bench grid and return the result it gives
	function automatic cell_reply_t apply_grid_op(input grid_beat_t b);
		cell_reply_t r;
		int cx, cy, idx;
		r = '0;
		case (b.op)
			OP_CLEAR: begin
				foreach (grid_cells[i])
					grid_cells[i] = '0;
			end
			OP_BIN: begin
				if (coord_to_cell(b.px, cx) && coord_to_cell(b.py, cy) &&
						cx < eff_dim(grid_w_reg) && cy < eff_dim(grid_h_reg)) begin
					idx = cy * DEF_MAX_WIDTH + cx;
					grid_cells[idx].material = b.mat;
					if (grid_cells[idx].count != COUNT_MAX)
						grid_cells[idx].count = grid_cells[idx].count + 16'd1;
					r.acc = 1'b1;
				end
			end
			OP_READ: begin
				cx = int'(b.col);
				cy = int'(b.row);
				if (cx < eff_dim(grid_w_reg) && cy < eff_dim(grid_h_reg)) begin
					idx = cy * DEF_MAX_WIDTH + cx;
					r.acc      = 1'b1;
					r.material = grid_cells[idx].material;
					r.density  = grid_cells[idx].count;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// line index near either edge of the grid, a little past it at times
	function automatic int hot_line(input int eff);
		if ($urandom_range(0, 1) == 1 && eff > 8)
			return eff - 8 + int'($urandom_range(0, 9));
		return int'($urandom_range(0, 9));
	endfunction

	// Q12.8 position on a line, now and then a small negative value
	function automatic logic [19:0] hot_pos(input int line);
		if ($urandom_range(0, 9) == 0)
			return {12'hFFF, 8'($urandom)};
		return {1'b0, 11'(line), 8'($urandom)};
	endfunction

	// mostly bins and reads around the grid edges, some raw noise
	function automatic grid_beat_t random_beat();
		grid_beat_t b;
		int pick, cx, cy;
		b     = '0;
		pick  = int'($urandom_range(0, 99));
		cx    = hot_line(eff_dim(grid_w_reg));
		cy    = hot_line(eff_dim(grid_h_reg));
		b.px  = 20'($urandom);
		b.py  = 20'($urandom);
		b.mat = 8'($urandom);
		b.col = 8'($urandom);
		b.row = 8'($urandom);
		if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
			clears_left--;
			b.op = OP_CLEAR;
		end else if (pick < 55) begin
			b.op = OP_BIN;
			b.px = hot_pos(cx);
			b.py = hot_pos(cy);
		end else if (pick < 85) begin
			b.op  = OP_READ;
			b.col = 8'(cx);
			b.row = 8'(cy);
		end else if (pick < 92) begin
			b.op = OP_BIN;
		end else if (pick < 97) begin
			b.op = OP_READ;
		end else begin
			b.op = OP_NONE;
		end
		return b;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// present one beat, hold it until taken, then log its expected result
	task automatic send_beat(input grid_beat_t b);
		cell_reply_t predicted;
		while (!no_gaps && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		operation         <= b.op;
		pos_x             <= b.px;
		pos_y             <= b.py;
		particle_material <= b.mat;
		read_col          <= b.col;
		read_row          <= b.row;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_grid_op(b);
		if (b.fixed)
			predicted = {b.want_acc, b.want_mat, b.want_cnt};
		pending_replies = {pending_replies, predicted};
	endtask

	// sender holds off until every result beat has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_grid(input int w, input int h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data  <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data  <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_we    <= 1'b0;
		grid_w_reg = 9'(w);
		grid_h_reg = 9'(h);
	endtask

	// receiver stalls at random unless a no-gap stretch is running
	initial out_stall = 1'b0;
	always @(posedge clk)
		out_stall <= no_gaps ? 1'b0 : ($urandom_range(0, 99) < 36);

	// result checker
	always @(posedge clk) begin
		cell_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				flag_mismatch($sformatf("result beat with nothing pending (acc %0d mat %0d cnt %0d)",
					accepted, cell_material, cell_density));
			end else begin
				want = pending_replies.pop_front();
				if (accepted !== want.acc)
					flag_mismatch($sformatf("accepted got %0d expected %0d",
						accepted, want.acc));
				if (cell_material !== want.material)
					flag_mismatch($sformatf("cell_material got %0d expected %0d",
						cell_material, want.material));
				if (cell_density !== want.density)
					flag_mismatch($sformatf("cell_density got %0d expected %0d",
						cell_density, want.density));
			end
		end
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end

	// main sequence
	initial begin
		grid_beat_t b;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_GRID_WIDTH;
		cfg_data          = '0;
		in_valid          = 1'b0;
		operation         = OP_NONE;
		pos_x             = '0;
		pos_y             = '0;
		particle_material = '0;
		read_col          = '0;
		read_row          = '0;
		mismatches        = 0;
		clears_left       = 2;
		no_gaps           = 1'b0;
		grid_w_reg        = GRID_DIM_RESET;
		grid_h_reg        = GRID_DIM_RESET;
		foreach (grid_cells[i])
			grid_cells[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset grid size
		foreach (directed_rows[i])
			send_beat(directed_rows[i]);
		wait_drained();

		// one cell hit back to back with no idling on either side, then read
		no_gaps = 1'b1;
		b       = '0;
		b.op    = OP_BIN;
		repeat (60) begin
			b.px  = {1'b0, 11'd5, 8'($urandom)};
			b.py  = {1'b0, 11'd7, 8'($urandom)};
			b.mat = 8'($urandom);
			send_beat(b);
		end
		b     = '0;
		b.op  = OP_READ;
		b.col = 8'd5;
		b.row = 8'd7;
		send_beat(b);
		wait_drained();
		no_gaps = 1'b0;

		// random phases over several grid sizes
		phase_w[6] = $urandom_range(1, 256);
		phase_h[6] = $urandom_range(1, 256);
		phase_w[7] = $urandom_range(257, 511);
		phase_h[7] = $urandom_range(1, 40);
		foreach (phase_w[p]) begin
			wait_drained();
			write_grid(phase_w[p], phase_h[p]);
			repeat (100)
				send_beat(random_beat());
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
src/pgb_pkg.sv
src/pgb_cell_mem.sv
src/particle_grid_binning.sv
verif/tb_top.sv
